// ===== hdl/lsfp_pkg.sv =====
// Shared types, constants and helpers of the line sensor frame position block.
`default_nettype none
package lsfp_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] CMD_GRAY    = 8'h80;
    localparam logic [7:0] CMD_BIN     = 8'h81;
    localparam logic [7:0] CMD_GRAY_LO = 8'h82;
    localparam logic [7:0] CMD_GRAY_HI = 8'h86;

    localparam logic [15:0]       MIN_START    = 16'd4095;
    localparam logic signed [17:0] CONTRAST_MIN = 18'sd500;
    localparam logic [9:0]        NORM_SCALE   = 10'd1000;
    localparam logic [6:0]        POS_LIMIT    = 7'd100;
    localparam logic [7:0]        NO_LINE      = 8'h80;
    localparam logic [15:0]       THIRD_RECIP  = 16'hAAAB;

    localparam logic KIND_GRAY = 1'b0;
    localparam logic KIND_BIN  = 1'b1;

    // divider widths: dividend up to 65535 * 1000, divisor up to 65535
    localparam int DIV_W  = 26;
    localparam int DSR_W  = 18;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COMMAND,
        PH_GRAY,
        PH_BINARY
    } phase_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SCAN,
        BK_CHECK,
        BK_NORM,
        BK_NWAIT,
        BK_POS,
        BK_PWAIT,
        BK_COUNT,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic              kind;
        logic [7:0][15:0]  gray;
        logic [7:0]        bin;
    } frame_word_t;

    typedef struct packed {
        logic              frame_kind;
        logic [7:0]        line_position;
        logic              line_found;
        logic              line_found_count_rule;
        logic [7:0]        binary_bits;
    } result_t;

    function automatic logic signed [7:0] weight(input logic [CH_W-1:0] idx);
        logic signed [7:0] w;
        case (idx)
            3'd0:    w = -8'sd70;
            3'd1:    w = -8'sd57;
            3'd2:    w = -8'sd28;
            3'd3:    w = -8'sd14;
            3'd4:    w = 8'sd14;
            3'd5:    w = 8'sd28;
            3'd6:    w = 8'sd57;
            3'd7:    w = 8'sd70;
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lsfp_front.sv =====
// Frame parser: header and command decode, gray and binary capture.
`default_nettype none
module lsfp_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rx_valid,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 q_full,
    output logic                      rx_stall,
    output logic                      q_push,
    output lsfp_pkg::frame_word_t     q_word
);
    import lsfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_count_reg;
    logic [7:0]  frame_bytes_reg [2*CHANNELS];
    logic [7:0][15:0] gray_reg;
    logic [7:0]  bin_reg;
    logic        take;
    logic        gray_done;
    logic [7:0][15:0] gray_new;

    assign rx_stall = q_full;
    assign take     = rx_valid && !rx_stall;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte == HDR_BYTE)
                        phase_next = PH_COMMAND;
                end
                PH_COMMAND:
                begin
                    if (rx_byte inside {CMD_GRAY, [CMD_GRAY_LO:CMD_GRAY_HI]})
                        phase_next = PH_GRAY;
                    else if (rx_byte == CMD_BIN)
                        phase_next = PH_BINARY;
                    else
                        phase_next = PH_HEADER;
                end
                PH_GRAY:
                begin
                    if (byte_count_reg == 4'hF)
                        phase_next = PH_HEADER;
                end
                PH_BINARY: phase_next = PH_HEADER;
                default:   phase_next = PH_HEADER;
            endcase
        end
    end

    // assemble the gray values with the last byte in flight
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            gray_new[i] = {frame_bytes_reg[2*i], frame_bytes_reg[2*i+1]};
        gray_new[CHANNELS-1][7:0] = rx_byte;
    end

    // outputs
    always_comb
    begin
        gray_done = 1'b0;
        q_push    = 1'b0;
        q_word    = '{kind: KIND_GRAY, gray: gray_reg, bin: bin_reg};
        case (phase_reg)
            PH_GRAY:
            begin
                gray_done = take && (byte_count_reg == 4'hF);
                q_push    = gray_done;
                q_word    = '{kind: KIND_GRAY, gray: gray_new, bin: bin_reg};
            end
            PH_BINARY:
            begin
                q_push = take;
                q_word = '{kind: KIND_BIN, gray: gray_reg, bin: rx_byte};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            gray_reg       <= '0;
            bin_reg        <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (take && phase_reg == PH_COMMAND)
                byte_count_reg <= '0;
            else if (take && phase_reg == PH_GRAY)
                byte_count_reg <= byte_count_reg + 4'd1;
            if (gray_done)
                gray_reg <= gray_new;
            if (take && phase_reg == PH_BINARY)
                bin_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && phase_reg == PH_GRAY)
            frame_bytes_reg[byte_count_reg] <= rx_byte;
    end

endmodule
`default_nettype wire

// ===== hdl/lsfp_queue.sv =====
// Two-entry queue of completed frame words between parser and detector.
`default_nettype none
module lsfp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lsfp_pkg::frame_word_t push_word,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       empty,
    output lsfp_pkg::frame_word_t      head_word
);
    import lsfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    frame_word_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    fill_reg;

    assign full      = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign head_word = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule
`default_nettype wire

// ===== hdl/lsfp_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lsfp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lsfp_pkg::DIV_W-1:0]  dividend,
    input  wire logic [lsfp_pkg::DSR_W-1:0]  divisor,
    output logic                             done,
    output logic [lsfp_pkg::DIV_W-1:0]       quotient
);
    import lsfp_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DSR_W-1:0]  rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    shifted;
    logic              ge;
    logic [DSR_W:0]    diff;

    assign shifted  = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = shifted >= {1'b0, dsr_reg};
    assign diff     = shifted - {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lsfp_back.sv =====
// Line detector sequencer: min/max scan, normalize, centroid, count rule.
`default_nettype none
module lsfp_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire lsfp_pkg::frame_word_t q_word,
    input  wire logic [7:0]            channel_mask,
    input  wire logic                  res_stall,
    output logic                       q_pop,
    output logic                       res_valid,
    output lsfp_pkg::result_t          res_word
);
    import lsfp_pkg::*;

    back_state_t       state_reg, state_next;
    frame_word_t       word_reg;
    logic [CH_W-1:0]   idx_reg;
    logic [15:0]       lo_m_reg, hi_m_reg, lo_a_reg, hi_a_reg;
    logic [15:0]       span_reg;
    logic [14:0]       third_reg;
    logic              count_ok_reg;
    logic signed [20:0] sum_w_reg;
    logic [12:0]       sum_v_reg;
    logic [7:0]        pos_reg;
    logic [3:0]        cnt_reg;
    logic              res_valid_reg;
    result_t           res_word_reg;

    logic [15:0]        g_sel;
    logic               last;
    logic signed [17:0] span_m, span_a;
    logic [31:0]        third_prod;
    logic signed [18:0] term;
    logic [20:0]        abs_w;
    logic [6:0]         mag;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DSR_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    assign g_sel      = word_reg.gray[idx_reg];
    assign last       = (idx_reg == CH_W'(CHANNELS-1));
    assign span_m     = $signed({2'b00, hi_m_reg}) - $signed({2'b00, lo_m_reg});
    assign span_a     = $signed({2'b00, hi_a_reg}) - $signed({2'b00, lo_a_reg});
    assign third_prod = span_a[15:0] * THIRD_RECIP;
    assign term       = $signed({1'b0, div_q[9:0]}) * weight(idx_reg);
    assign abs_w      = sum_w_reg[20] ? 21'(-sum_w_reg) : 21'(sum_w_reg);
    assign mag        = (div_q > DIV_W'(POS_LIMIT)) ? POS_LIMIT : div_q[6:0];

    lsfp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  if (!q_empty && !res_valid_reg) state_next = BK_SCAN;
            BK_SCAN:  if (last) state_next = BK_CHECK;
            BK_CHECK: state_next = (span_m >= CONTRAST_MIN) ? BK_NORM : BK_COUNT;
            BK_NORM:
            begin
                if (channel_mask[idx_reg])
                    state_next = BK_NWAIT;
                else if (last)
                    state_next = BK_POS;
            end
            BK_NWAIT: if (div_done) state_next = last ? BK_POS : BK_NORM;
            BK_POS:   state_next = (sum_v_reg == '0) ? BK_COUNT : BK_PWAIT;
            BK_PWAIT: if (div_done) state_next = BK_COUNT;
            BK_COUNT: if (last) state_next = BK_DONE;
            BK_DONE:  state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(g_sel - lo_m_reg) * DIV_W'(NORM_SCALE);
        div_divisor  = DSR_W'(span_reg);
        case (state_reg)
            BK_IDLE: q_pop = !q_empty && !res_valid_reg;
            BK_NORM: div_start = channel_mask[idx_reg];
            BK_POS:
            begin
                div_start    = (sum_v_reg != '0);
                div_dividend = DIV_W'(abs_w[19:0]);
                div_divisor  = DSR_W'(sum_v_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_DONE)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                word_reg <= q_word;
                idx_reg  <= '0;
                lo_m_reg <= MIN_START;
                hi_m_reg <= '0;
                lo_a_reg <= MIN_START;
                hi_a_reg <= '0;
            end
            BK_SCAN:
            begin
                if (channel_mask[idx_reg])
                begin
                    if (g_sel < lo_m_reg) lo_m_reg <= g_sel;
                    if (g_sel > hi_m_reg) hi_m_reg <= g_sel;
                end
                if (g_sel < lo_a_reg) lo_a_reg <= g_sel;
                if (g_sel > hi_a_reg) hi_a_reg <= g_sel;
                idx_reg <= idx_reg + 1'b1;
            end
            BK_CHECK:
            begin
                span_reg     <= span_m[15:0];
                count_ok_reg <= (span_a >= CONTRAST_MIN);
                third_reg    <= third_prod[31:17];
                sum_w_reg    <= '0;
                sum_v_reg    <= '0;
                pos_reg      <= NO_LINE;
                cnt_reg      <= '0;
                idx_reg      <= '0;
            end
            BK_NORM:
            begin
                if (!channel_mask[idx_reg])
                    idx_reg <= idx_reg + 1'b1;
            end
            BK_NWAIT:
            begin
                if (div_done)
                begin
                    sum_w_reg <= sum_w_reg + 21'(term);
                    sum_v_reg <= sum_v_reg + 13'(div_q[9:0]);
                    idx_reg   <= idx_reg + 1'b1;
                end
            end
            BK_PWAIT:
            begin
                if (div_done)
                    pos_reg <= sum_w_reg[20] ? 8'(-{1'b0, mag}) : {1'b0, mag};
            end
            BK_COUNT:
            begin
                if (count_ok_reg && (g_sel - lo_a_reg) > {1'b0, third_reg})
                    cnt_reg <= cnt_reg + 4'd1;
                idx_reg <= idx_reg + 1'b1;
            end
            BK_DONE:
            begin
                res_word_reg.frame_kind            <= word_reg.kind;
                res_word_reg.line_position         <= pos_reg;
                res_word_reg.line_found            <= (pos_reg != NO_LINE);
                res_word_reg.line_found_count_rule <= (cnt_reg >= 4'd2);
                res_word_reg.binary_bits           <= word_reg.bin;
            end
            default: ;
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
`default_nettype wire

// ===== hdl/line_sensor_frame_position.sv =====
// Top level of the line sensor frame position block.
// Divider: the detector runs up to nine divisions per frame on one shared
//   26-step divider, one per enabled channel and one for the position.
// Throughput: one frame per detector pass; a two-word queue absorbs bursts.
// Reset: rst_n asynchronous, active low; parser waits for a header, stored
//   gray values and binary bits clear to zero, channel_mask returns to 0xFF.
`default_nettype none
module line_sensor_frame_position (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: one register, written whenever the enable is high
    input  wire logic              channel_mask_we,
    input  wire logic [7:0]        channel_mask,
    // received byte channel
    input  wire logic              rx_valid,
    output logic                   rx_stall,
    input  wire logic [7:0]        rx_byte,
    // result channel
    output logic                   res_valid,
    input  wire logic              res_stall,
    output logic                   frame_kind,
    output logic signed [7:0]      line_position,
    output logic                   line_found,
    output logic                   line_found_count_rule,
    output logic [7:0]             binary_bits
);
    import lsfp_pkg::*;

    logic [7:0]  channel_mask_reg;
    logic        q_push, q_pop, q_full, q_empty;
    frame_word_t push_word, head_word;
    result_t     res_word;

    // hold the channel mask; the detector samples it while it runs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_mask_reg <= 8'hFF;
        else if (channel_mask_we)
            channel_mask_reg <= channel_mask;
    end

    // front: parse bytes, push one word per completed frame
    lsfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .rx_stall (rx_stall),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    // decouple parser from detector
    lsfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_word (head_word)
    );

    // back: run both line detections on each word
    lsfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_word       (head_word),
        .channel_mask (channel_mask_reg),
        .res_stall    (res_stall),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_word     (res_word)
    );

    assign frame_kind            = res_word.frame_kind;
    assign line_position         = $signed(res_word.line_position);
    assign line_found            = res_word.line_found;
    assign line_found_count_rule = res_word.line_found_count_rule;
    assign binary_bits           = res_word.binary_bits;

endmodule
`default_nettype wire

// ===== hdl/lsfp_checker.sv =====
// Port-level checks of the line sensor frame position block, bound to the top.
`default_nettype none
module lsfp_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              channel_mask_we,
    input  wire logic [7:0]        channel_mask,
    input  wire logic              rx_valid,
    input  wire logic              rx_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              res_valid,
    input  wire logic              res_stall,
    input  wire logic              frame_kind,
    input  wire logic signed [7:0] line_position,
    input  wire logic              line_found,
    input  wire logic              line_found_count_rule,
    input  wire logic [7:0]        binary_bits
);
    import lsfp_pkg::*;

    // found flag agrees with the no-line code
    a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (line_found == (line_position != $signed(NO_LINE))))
        else $error("line_found disagrees with line_position");

    // a found position stays inside the clamp
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && line_found) |->
            (line_position >= -8'sd100 && line_position <= 8'sd100))
        else $error("line_position out of range");

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
            (res_valid && $stable(line_position) && $stable(frame_kind)
             && $stable(binary_bits) && $stable(line_found_count_rule)))
        else $error("stalled result changed");

endmodule

bind line_sensor_frame_position lsfp_checker u_lsfp_checker (.*);
`default_nettype wire
